// ----- hw/rtl/tsf_pkg.sv -----
// shared types and constants for the touch sample filter
// no dependencies
`default_nettype none

package tsf_pkg;

    localparam int RAW_W      = 12;
    localparam int COORD_W    = 16;
    localparam int GAIN_W     = 17;
    localparam int OFFS_W     = 12;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int KIND_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAW      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_WINDOW = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SCANS   = 4'd7;

    // group record kinds passed from front to back
    localparam logic [KIND_W-1:0] K_X1      = 3'd0;
    localparam logic [KIND_W-1:0] K_Y1_OK   = 3'd1;
    localparam logic [KIND_W-1:0] K_Y1_FAIL = 3'd2;
    localparam logic [KIND_W-1:0] K_X2      = 3'd3;
    localparam logic [KIND_W-1:0] K_Y2      = 3'd4;
    localparam logic [KIND_W-1:0] K_REL     = 3'd5;

    localparam logic [COORD_W-1:0] COORD_NONE = 16'hFFFF;
    localparam logic [HOLD_W-1:0]  PRESS_MAX  = 8'd255;

    // reset values of the configuration registers
    localparam logic                     RST_RAW_MODE     = 1'b0;
    localparam logic signed [GAIN_W-1:0] RST_X_GAIN       = 17'sd4372;
    localparam logic signed [GAIN_W-1:0] RST_Y_GAIN       = 17'sd5975;
    localparam logic signed [OFFS_W-1:0] RST_X_OFFSET     = -12'sd11;
    localparam logic signed [OFFS_W-1:0] RST_Y_OFFSET     = -12'sd18;
    localparam logic [RAW_W-1:0]         RST_MIN_RAW      = 12'd50;
    localparam logic [RAW_W-1:0]         RST_AGREE_WINDOW = 12'd50;
    localparam logic [HOLD_W-1:0]        RST_HOLD_SCANS   = 8'd2;

    typedef struct packed {
        logic        op;
        logic [15:0] raw_word;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] down_x;
        logic [COORD_W-1:0] down_y;
        logic [COORD_W-1:0] up_x;
        logic [COORD_W-1:0] up_y;
        logic               read_ok;
    } t_out;

    typedef struct packed {
        logic                     raw_mode;
        logic signed [GAIN_W-1:0] x_gain;
        logic signed [GAIN_W-1:0] y_gain;
        logic signed [OFFS_W-1:0] x_offset;
        logic signed [OFFS_W-1:0] y_offset;
        logic [RAW_W-1:0]         min_raw;
        logic [RAW_W-1:0]         agree_window;
        logic [HOLD_W-1:0]        hold_scans;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/tsf_queue.sv -----
// small first-in first-out queue of fixed-width words
// no dependencies
`default_nettype none

module tsf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, do_pop})
                2'b10: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                2'b01: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsf_front.sv -----
// front end: takes read words, keeps running sum, min and max per group
// and classifies each finished group or release word; depends on tsf_pkg
`default_nettype none

module tsf_front #(
    parameter int N      = 5,
    parameter int TSUM_W = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  tsf_pkg::t_in                        i_item,
    input  logic [tsf_pkg::RAW_W-1:0]           i_min_raw,
    output logic                                o_rec_push,
    output logic [tsf_pkg::KIND_W+TSUM_W-1:0]   o_rec
);

    localparam int DIV   = N - 2;
    localparam int CNT_W = $clog2(N);
    localparam int SUM_W = $clog2(N * 4095 + 1);
    localparam int DIV_W = $clog2(DIV + 1);
    localparam int MP_W  = tsf_pkg::RAW_W + DIV_W;
    localparam int CMP_W = (MP_W > TSUM_W) ? MP_W : TSUM_W;

    logic [CNT_W-1:0]          r_cnt;
    logic [1:0]                r_grp;
    logic [TSUM_W-1:0]         r_x1_tsum;
    logic [SUM_W-1:0]          r_sum;
    logic [tsf_pkg::RAW_W-1:0] r_min;
    logic [tsf_pkg::RAW_W-1:0] r_max;

    logic [SUM_W-1:0]           n_sum;
    logic [tsf_pkg::RAW_W-1:0]  n_min;
    logic [tsf_pkg::RAW_W-1:0]  n_max;
    logic [tsf_pkg::RAW_W-1:0]  sample;
    logic                       first;
    logic                       last;
    logic [SUM_W-1:0]           trim_full;
    logic [TSUM_W-1:0]          tsum;
    logic [MP_W-1:0]            min_prod;
    logic                       low;
    logic                       x1_low;
    logic                       y1_fail;
    logic [tsf_pkg::KIND_W-1:0] kind;

    assign sample    = i_item.raw_word[15:4];
    assign first     = (r_cnt == '0);
    assign last      = (r_cnt == CNT_W'(N - 1));
    assign n_sum     = first ? SUM_W'(sample) : r_sum + SUM_W'(sample);
    assign n_min     = (first || sample < r_min) ? sample : r_min;
    assign n_max     = (first || sample > r_max) ? sample : r_max;
    assign trim_full = n_sum - SUM_W'(n_min) - SUM_W'(n_max);
    assign tsum      = TSUM_W'(trim_full);
    // mean below min_raw is the same as trimmed sum below min_raw times the divisor
    assign min_prod  = MP_W'(i_min_raw) * MP_W'(DIV);
    assign low       = CMP_W'(tsum) < CMP_W'(min_prod);
    assign x1_low    = CMP_W'(r_x1_tsum) < CMP_W'(min_prod);
    assign y1_fail   = x1_low || low;

    always_comb begin
        case (r_grp)
            2'd0: begin
                kind = tsf_pkg::K_X1;
            end
            2'd1: begin
                kind = y1_fail ? tsf_pkg::K_Y1_FAIL : tsf_pkg::K_Y1_OK;
            end
            2'd2: begin
                kind = tsf_pkg::K_X2;
            end
            default: begin
                kind = tsf_pkg::K_Y2;
            end
        endcase
    end

    assign o_rec_push = i_push && (i_item.op || last);
    assign o_rec      = i_item.op ? {tsf_pkg::K_REL, TSUM_W'(0)} : {kind, tsum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_grp     <= '0;
            r_x1_tsum <= '0;
        end else if (i_push) begin
            if (i_item.op) begin
                r_cnt <= '0;
                r_grp <= '0;
            end else if (last) begin
                r_cnt <= '0;
                case (r_grp)
                    2'd0: begin
                        r_grp     <= 2'd1;
                        r_x1_tsum <= tsum;
                    end
                    2'd1: begin
                        r_grp <= y1_fail ? 2'd0 : 2'd2;
                    end
                    2'd2: begin
                        r_grp <= 2'd3;
                    end
                    default: begin
                        r_grp <= 2'd0;
                    end
                endcase
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !i_item.op) begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsf_back.sv -----
// back end: divides group sums, checks pairs, calibrates and keeps the
// coordinate and press state; depends on tsf_pkg
`default_nettype none

module tsf_back #(
    parameter int N      = 5,
    parameter int TSUM_W = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsf_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_empty,
    input  logic [tsf_pkg::KIND_W+TSUM_W-1:0] i_rec,
    output logic                              o_q_pop,
    input  logic                              i_out_full,
    output logic                              o_out_push,
    output tsf_pkg::t_out                     o_result
);

    localparam int RAW_W   = tsf_pkg::RAW_W;
    localparam int COORD_W = tsf_pkg::COORD_W;
    localparam int KIND_W  = tsf_pkg::KIND_W;
    localparam int DIV     = N - 2;
    localparam int DIV_W   = $clog2(DIV + 1);
    localparam int K       = TSUM_W;
    localparam int PROD_W  = TSUM_W + K + 1;
    localparam int QD_W    = TSUM_W + DIV_W;
    localparam int MUL_W   = tsf_pkg::GAIN_W + RAW_W + 1;
    localparam int VAL_W   = 32;
    localparam logic [K:0] RECIP = (K + 1)'((64'd1 << K) / DIV);

    logic en;

    // stage 1: reciprocal product
    logic              r1_valid;
    logic [KIND_W-1:0] r1_kind;
    logic [TSUM_W-1:0] r1_tsum;
    logic [PROD_W-1:0] r1_prod;
    // stage 2: group mean
    logic              r2_valid;
    logic [KIND_W-1:0] r2_kind;
    logic [RAW_W-1:0]  r2_mean;
    // stage 3: pair checks and averages
    logic              r3_valid;
    logic              r3_rel;
    logic              r3_ok;
    logic [RAW_W-1:0]  r3_ax;
    logic [RAW_W-1:0]  r3_ay;
    // stage 4: calibration products
    logic                    r4_valid;
    logic                    r4_rel;
    logic                    r4_ok;
    logic [RAW_W-1:0]        r4_ax;
    logic [RAW_W-1:0]        r4_ay;
    logic signed [MUL_W-1:0] r4_px;
    logic signed [MUL_W-1:0] r4_py;

    logic [RAW_W-1:0]          r_fx;
    logic [RAW_W-1:0]          r_fy;
    logic [RAW_W-1:0]          r_sx;
    logic [COORD_W-1:0]        r_last_x;
    logic [COORD_W-1:0]        r_last_y;
    logic [tsf_pkg::HOLD_W-1:0] r_press;

    logic [KIND_W-1:0] rec_kind;
    logic [TSUM_W-1:0] rec_tsum;
    logic [TSUM_W-1:0] q0;
    logic [QD_W-1:0]   qd;
    logic [QD_W-1:0]   rem;
    logic [TSUM_W-1:0] qc;

    logic [RAW_W-1:0] dx;
    logic [RAW_W-1:0] dy;
    logic [RAW_W:0]   sum_x;
    logic [RAW_W:0]   sum_y;
    logic             y2_ok;
    logic             is_result;

    logic signed [VAL_W-1:0] val_x;
    logic signed [VAL_W-1:0] val_y;
    logic [COORD_W-1:0]      cal_x;
    logic [COORD_W-1:0]      cal_y;
    logic [COORD_W-1:0]      new_x;
    logic [COORD_W-1:0]      new_y;
    logic                    up_seen;

    assign en         = !r4_valid || !i_out_full;
    assign o_q_pop    = en && !i_q_empty;
    assign o_out_push = r4_valid && !i_out_full;
    assign rec_kind   = i_rec[KIND_W+TSUM_W-1:TSUM_W];
    assign rec_tsum   = i_rec[TSUM_W-1:0];

    // divide by the constant through its reciprocal, then one correction step
    assign q0  = r1_prod[K +: TSUM_W];
    assign qd  = QD_W'(q0) * QD_W'(DIV);
    assign rem = QD_W'(r1_tsum) - qd;
    assign qc  = (rem >= QD_W'(DIV)) ? q0 + 1'b1 : q0;

    assign dx    = (r_fx > r_sx) ? r_fx - r_sx : r_sx - r_fx;
    assign dy    = (r_fy > r2_mean) ? r_fy - r2_mean : r2_mean - r_fy;
    assign sum_x = {1'b0, r_fx} + {1'b0, r_sx};
    assign sum_y = {1'b0, r_fy} + {1'b0, r2_mean};
    assign y2_ok = (r_sx >= i_cfg.min_raw) && (r2_mean >= i_cfg.min_raw)
                   && (dx < i_cfg.agree_window) && (dy < i_cfg.agree_window);
    assign is_result = (r2_kind == tsf_pkg::K_Y1_FAIL) || (r2_kind == tsf_pkg::K_Y2)
                       || (r2_kind == tsf_pkg::K_REL);

    assign val_x = VAL_W'(r4_px) + (VAL_W'(i_cfg.x_offset) <<< 16);
    assign val_y = VAL_W'(r4_py) + (VAL_W'(i_cfg.y_offset) <<< 16);
    assign cal_x = val_x[VAL_W-1] ? '0 : val_x[VAL_W-1 -: COORD_W];
    assign cal_y = val_y[VAL_W-1] ? '0 : val_y[VAL_W-1 -: COORD_W];
    assign new_x = i_cfg.raw_mode ? COORD_W'(r4_ax) : cal_x;
    assign new_y = i_cfg.raw_mode ? COORD_W'(r4_ay) : cal_y;
    assign up_seen = r_press > i_cfg.hold_scans;

    always_comb begin
        if (r4_rel) begin
            o_result.down_x  = tsf_pkg::COORD_NONE;
            o_result.down_y  = tsf_pkg::COORD_NONE;
            o_result.up_x    = up_seen ? r_last_x : tsf_pkg::COORD_NONE;
            o_result.up_y    = up_seen ? r_last_y : tsf_pkg::COORD_NONE;
            o_result.read_ok = 1'b0;
        end else begin
            o_result.down_x  = r4_ok ? new_x : r_last_x;
            o_result.down_y  = r4_ok ? new_y : r_last_y;
            o_result.up_x    = tsf_pkg::COORD_NONE;
            o_result.up_y    = tsf_pkg::COORD_NONE;
            o_result.read_ok = r4_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= !i_q_empty;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && is_result;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= rec_kind;
            r1_tsum <= rec_tsum;
            r1_prod <= PROD_W'(rec_tsum) * PROD_W'(RECIP);
            r2_kind <= r1_kind;
            r2_mean <= RAW_W'(qc);
            r3_rel  <= (r2_kind == tsf_pkg::K_REL);
            r3_ok   <= (r2_kind == tsf_pkg::K_Y2) && y2_ok;
            r3_ax   <= sum_x[RAW_W:1];
            r3_ay   <= sum_y[RAW_W:1];
            r4_rel  <= r3_rel;
            r4_ok   <= r3_ok;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_px   <= MUL_W'(i_cfg.x_gain) * MUL_W'($signed({1'b0, r3_ax}));
            r4_py   <= MUL_W'(i_cfg.y_gain) * MUL_W'($signed({1'b0, r3_ay}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0;
            r_fy <= '0;
            r_sx <= '0;
        end else if (en && r2_valid) begin
            case (r2_kind)
                tsf_pkg::K_X1: begin
                    r_fx <= r2_mean;
                end
                tsf_pkg::K_Y1_OK, tsf_pkg::K_Y1_FAIL: begin
                    r_fy <= r2_mean;
                end
                tsf_pkg::K_X2: begin
                    r_sx <= r2_mean;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_press  <= '0;
        end else if (o_out_push) begin
            if (r4_rel) begin
                r_press <= '0;
            end else begin
                if (r_press != tsf_pkg::PRESS_MAX) begin
                    r_press <= r_press + 1'b1;
                end
                if (r4_ok) begin
                    r_last_x <= new_x;
                    r_last_y <= new_y;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/touch_sample_filter.sv -----
// touch sample filter, top level: one read word accepted per cycle while full is low
// a result comes from the word that ends a scan or the release word, through
// the record queue and four back-end stages (reciprocal, mean, check, multiply)
// synchronous active-low reset clears control, counters, coordinates and press
// count and loads the default calibration; no clearing pass
`default_nettype none

module touch_sample_filter #(
    parameter int SAMPLES_PER_AXIS = 5,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  tsf_pkg::t_in                      i_item,
    output logic                              empty,
    input  logic                              pop,
    output tsf_pkg::t_out                     o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DIV       = SAMPLES_PER_AXIS - 2;
    localparam int TSUM_W    = $clog2(DIV * 4095 + 1);
    localparam int REC_W     = tsf_pkg::KIND_W + TSUM_W;
    localparam int OUT_W     = $bits(tsf_pkg::t_out);
    localparam int OUT_DEPTH = 2;

    tsf_pkg::t_cfg r_cfg;

    logic             in_acc;
    logic             q_push;
    logic [REC_W-1:0] q_wdata;
    logic [REC_W-1:0] q_rdata;
    logic             q_pop;
    logic             q_empty;
    logic             out_push;
    logic             out_full;
    tsf_pkg::t_out    out_data;
    logic [OUT_W-1:0] out_rdata;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = push && !full;
    assign o_result    = tsf_pkg::t_out'(out_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_mode     <= tsf_pkg::RST_RAW_MODE;
            r_cfg.x_gain       <= tsf_pkg::RST_X_GAIN;
            r_cfg.y_gain       <= tsf_pkg::RST_Y_GAIN;
            r_cfg.x_offset     <= tsf_pkg::RST_X_OFFSET;
            r_cfg.y_offset     <= tsf_pkg::RST_Y_OFFSET;
            r_cfg.min_raw      <= tsf_pkg::RST_MIN_RAW;
            r_cfg.agree_window <= tsf_pkg::RST_AGREE_WINDOW;
            r_cfg.hold_scans   <= tsf_pkg::RST_HOLD_SCANS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsf_pkg::REG_RAW_MODE: begin
                    r_cfg.raw_mode <= i_cfg_data[0];
                end
                tsf_pkg::REG_X_GAIN: begin
                    r_cfg.x_gain <= i_cfg_data;
                end
                tsf_pkg::REG_Y_GAIN: begin
                    r_cfg.y_gain <= i_cfg_data;
                end
                tsf_pkg::REG_X_OFFSET: begin
                    r_cfg.x_offset <= i_cfg_data[tsf_pkg::OFFS_W-1:0];
                end
                tsf_pkg::REG_Y_OFFSET: begin
                    r_cfg.y_offset <= i_cfg_data[tsf_pkg::OFFS_W-1:0];
                end
                tsf_pkg::REG_MIN_RAW: begin
                    r_cfg.min_raw <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                end
                tsf_pkg::REG_AGREE_WINDOW: begin
                    r_cfg.agree_window <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                end
                tsf_pkg::REG_HOLD_SCANS: begin
                    r_cfg.hold_scans <= i_cfg_data[tsf_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tsf_front #(
        .N      (SAMPLES_PER_AXIS),
        .TSUM_W (TSUM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_acc),
        .i_item     (i_item),
        .i_min_raw  (r_cfg.min_raw),
        .o_rec_push (q_push),
        .o_rec      (q_wdata)
    );

    tsf_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (full),
        .o_empty (q_empty)
    );

    tsf_back #(
        .N      (SAMPLES_PER_AXIS),
        .TSUM_W (TSUM_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_rec      (q_rdata),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_result   (out_data)
    );

    tsf_queue #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (OUT_W'(out_data)),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_full  (out_full),
        .o_empty (empty)
    );

`ifndef SYNTH
    a_rec_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !full)
        else $error("group record pushed into a full queue");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full output queue");

    a_ok_has_no_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.read_ok) |->
        (o_result.up_x == tsf_pkg::COORD_NONE && o_result.up_y == tsf_pkg::COORD_NONE))
        else $error("good read carries an up coordinate");
`endif

endmodule

`default_nettype wire
